// ===== src/touch_packet_parser_core_defines.svh =====
// Assertion macros shared by the touch packet parser checkers.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef TOUCH_PACKET_PARSER_CORE_DEFINES_SVH
`define TOUCH_PACKET_PARSER_CORE_DEFINES_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define TPP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define TPP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/tpp_pkg.sv =====
// Package for the touch packet parser: character codes, sizes and payload types.
// No dependencies.
`timescale 1ns / 1ps

package tpp_pkg;

   // Packet geometry
   localparam int unsigned PKT_LEN = 10;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned COMMA_POS = 5;
   localparam int unsigned X_POS_START = 1;
   localparam int unsigned Y_POS_START = 6;
   localparam int unsigned DIGITS = 4;

   // Character codes
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_COMMA = 8'd44;
   localparam logic [7:0] CH_T     = 8'd84;
   localparam logic [7:0] CH_R     = 8'd82;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   // Y axis origin
   localparam logic signed [15:0] Y_BASE = 16'sd3072;

   // Request payload: one received serial byte
   typedef struct packed {
      logic [7:0] rx_byte;
   } tpp_req_type;

   // Result payload: one decoded packet
   typedef struct packed {
      logic               packet_good;
      logic [15:0]        x_pos;
      logic signed [15:0] y_pos;
      logic               touching;
   } tpp_rsp_type;

   // Buffered packet as seen by the decoder
   typedef struct packed {
      logic [PKT_LEN-1:0][7:0] data;
      logic [COUNT_W-1:0]      count;
   } tpp_packet_type;

endpackage

// ===== src/tpp_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Depends on nothing; payload type is set per instance.
`timescale 1ns / 1ps

interface tpp_stream_if #(
   parameter type payload_type = logic [7:0]
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/tpp_packet_buffer.sv =====
// Packet byte buffer and saturating byte count for the touch packet parser.
// Depends on tpp_pkg.
`timescale 1ns / 1ps

module tpp_packet_buffer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   store_en,
   input  logic                   clear_en,
   input  logic [7:0]             store_byte,
   output tpp_pkg::tpp_packet_type packet
);
   import tpp_pkg::*;

   logic [PKT_LEN-1:0][7:0] data_ff;
   logic [COUNT_W-1:0]      count_ff;
   logic [COUNT_W-1:0]      count_in;
   logic                    has_room;

   assign has_room = (count_ff < COUNT_W'(PKT_LEN));

   // Count saturates at the packet length; a carriage return clears it
   always_comb begin
      count_in = count_ff;
      if (clear_en) begin
         count_in = '0;
      end else if (store_en && has_room) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Byte storage, no reset needed
   always_ff @(posedge clock) begin
      if (store_en && has_room) begin
         data_ff[count_ff] <= store_byte;
      end
   end

   assign packet.data  = data_ff;
   assign packet.count = count_ff;

endmodule

// ===== src/tpp_field_decode.sv =====
// Packet checks and coordinate conversion for the touch packet parser.
// Depends on tpp_pkg.
`timescale 1ns / 1ps

module tpp_field_decode (
   input  tpp_pkg::tpp_packet_type packet,
   output tpp_pkg::tpp_rsp_type    result
);
   import tpp_pkg::*;

   logic [13:0] x_dec;
   logic [13:0] y_dec;
   logic [14:0] y_triple;
   logic        type_ok;
   logic        good;

   // Four-digit decimal value, stops at the first non-digit
   function automatic logic [13:0] dec4(input logic [3:0][7:0] chars);
      logic [13:0] v;
      logic        run;
      logic [7:0]  c;
      v   = '0;
      run = 1'b1;
      for (int i = 0; i < DIGITS; i++) begin
         c = chars[i];
         if (c < CH_ZERO || c > CH_NINE) begin
            run = 1'b0;
         end
         if (run) begin
            v = 14'((v << 3) + (v << 1)) + 14'(c - CH_ZERO);
         end
      end
      return v;
   endfunction

   assign x_dec = dec4(packet.data[X_POS_START +: DIGITS]);
   assign y_dec = dec4(packet.data[Y_POS_START +: DIGITS]);
   assign y_triple = {y_dec, 1'b0} + {1'b0, y_dec};

   // Packet validity
   assign type_ok = (packet.data[0] == CH_T) || (packet.data[0] == CH_R);
   assign good    = (packet.count == COUNT_W'(PKT_LEN)) &&
                    (packet.data[COMMA_POS] == CH_COMMA) && type_ok;

   // Result fields, all zero for a bad packet
   always_comb begin
      result = '0;
      if (good) begin
         result.packet_good = 1'b1;
         result.x_pos       = {x_dec, 2'b00};
         result.y_pos       = Y_BASE - $signed({1'b0, y_triple});
         result.touching    = (packet.data[0] == CH_T);
      end
   end

endmodule

// ===== src/touch_packet_parser_core.sv =====
// Touch packet parser top level: request intake, packet buffer, decoder, result register.
// Depends on tpp_pkg, tpp_stream_if, tpp_packet_buffer and tpp_field_decode.
//
// Usage:
//   req_chan carries one serial byte per request (rx_byte). Bytes other than a
//   carriage return are stored, up to ten per packet; later ones are dropped.
//   A carriage return produces exactly one result on rsp_chan (packet_good,
//   x_pos, y_pos, touching) and restarts the packet.
//   Result timing: the result is registered and valid in the cycle after the carriage return is taken.
//   Throughput: one request per cycle, sustained while rsp_chan is not stalled; the
//   decode of a packet is a single pass from the byte buffer into the result register.
//   Stall: a result waits in the result register while rsp_chan.ready is low;
//   req_chan.ready then drops until that result is taken, and rises again in
//   the cycle it is taken.
//   Reset: synchronous, active high; clears the byte count and the result
//   valid flag. Buffer contents are not cleared.
`timescale 1ns / 1ps

module touch_packet_parser_core (
   input logic           clock,
   input logic           reset,
   tpp_stream_if.sink    req_chan,
   tpp_stream_if.source  rsp_chan
);
   import tpp_pkg::*;

   tpp_packet_type packet;
   tpp_rsp_type    decoded;
   tpp_rsp_type    rsp_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           req_take;
   logic           is_cr;

   // Take a request whenever the result slot is free or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign is_cr          = (req_chan.payload.rx_byte == CH_CR);

   tpp_packet_buffer u_buffer (
      .clock      (clock),
      .reset      (reset),
      .store_en   (req_take && !is_cr),
      .clear_en   (req_take && is_cr),
      .store_byte (req_chan.payload.rx_byte),
      .packet     (packet)
   );

   tpp_field_decode u_decode (
      .packet (packet),
      .result (decoded)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (req_take && is_cr) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && is_cr) begin
         rsp_ff <= decoded;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule

// ===== src/tpp_checker.sv =====
// Port-level checks for touch_packet_parser_core, attached by bind.
// Depends on tpp_pkg and touch_packet_parser_core_defines.svh.
`timescale 1ns / 1ps
`include "touch_packet_parser_core_defines.svh"

module tpp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_rx_byte,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               rsp_packet_good,
   input logic [15:0]        rsp_x_pos,
   input logic signed [15:0] rsp_y_pos,
   input logic               rsp_touching
);
   import tpp_pkg::*;

   logic        cr_take;
   logic        slot_free;
   logic [33:0] rsp_fields;
   logic        rsp_zero;

   assign cr_take    = req_valid && req_ready && (req_rx_byte == CH_CR);
   assign slot_free  = !rsp_valid || rsp_ready;
   assign rsp_fields = {rsp_packet_good, rsp_x_pos, rsp_y_pos, rsp_touching};
   assign rsp_zero   = (rsp_x_pos == 16'd0) && (rsp_y_pos == 16'sd0) && !rsp_touching;

   // A stalled result holds
   `TPP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fields), "stalled result changed")

   // Every carriage return yields a result next cycle
   `TPP_ASSERT_NEXT(a_cr_result, cr_take, rsp_valid, "carriage return gave no result")

   // No result appears without a carriage return
   `TPP_ASSERT_NEXT(a_no_spurious, slot_free && !cr_take, !rsp_valid, "result without carriage return")

   // Bad packets carry zero fields
   `TPP_ASSERT_NOW(a_bad_zero, rsp_valid && !rsp_packet_good, rsp_zero, "bad packet with nonzero fields")

   // X is always four times a decimal value
   `TPP_ASSERT_NOW(a_x_scale, rsp_valid && rsp_packet_good, rsp_x_pos[1:0] == 2'b00, "x_pos not a multiple of four")

endmodule

bind touch_packet_parser_core tpp_checker u_tpp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_rx_byte     (req_chan.payload.rx_byte),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_packet_good (rsp_chan.payload.packet_good),
   .rsp_x_pos       (rsp_chan.payload.x_pos),
   .rsp_y_pos       (rsp_chan.payload.y_pos),
   .rsp_touching    (rsp_chan.payload.touching)
);
